>>> hw/rtl/cct_pkg.sv
package cct_pkg;

	// Coordinate width (signed Q8.8 at the default) and step limit
	localparam int CW        = 16;
	localparam int MAX_STEPS = 63;
	localparam int SW        = 6;

	// Shared multiplier operand and product widths
	localparam int MA = 34;
	localparam int MB = (CW + 1 > 21) ? CW + 1 : 21;
	localparam int PW = MA + MB;

	// Accumulator width for one coordinate sum of four products
	localparam int AW = CW + 21;

	// Reciprocal of 6 on a 2^22 scale, exact for dividends below 2^21
	localparam logic [19:0] RECIP6 = 20'd699051;
	localparam int RECIP6_SHIFT = 22;

	// Configuration register indexes
	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_STEPS = 2'd1;

	// Curve modes
	localparam logic MODE_BEZIER  = 1'b0;
	localparam logic MODE_BSPLINE = 1'b1;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vertex_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PWR,
		ST_WNUM,
		ST_WDIV,
		ST_DOT,
		ST_OUT
	} state_t;

endpackage

>>> hw/rtl/cct_if.sv
// Vertex input channel
interface cct_vtx_if import cct_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   new_curve;
	coord_t vx;
	coord_t vy;
	coord_t vz;
	modport source(output valid, new_curve, vx, vy, vz, input ready);
	modport sink(input valid, new_curve, vx, vy, vz, output ready);
endinterface

// Curve point output channel
interface cct_pt_if import cct_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t px;
	coord_t py;
	coord_t pz;
	logic   last_point;
	modport source(output valid, px, py, pz, last_point, input ready);
	modport sink(input valid, px, py, pz, last_point, output ready);
endinterface

// Configuration write channel
interface cct_cfg_if import cct_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [1:0]    index;
	logic [SW-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/cubic_curve_tessellator.sv
// Cubic curve tessellator. Control vertices enter on vtx, one item each, and are kept in a
// four-entry window; a complete Bezier or uniform B-spline segment produces steps+1 points
// on pt (two when steps is zero), the last one flagged by last_point. Vertices are taken
// only while the block is idle. A radix-2 divider first forms 65536/steps; each point then
// ends in an output state that holds until pt.ready. Every cubic power, every B-spline
// divide by six and the twelve weight-coordinate products go one per cycle through a
// single shared multiplier, which sets the point rate. A vertex that completes no segment
// is absorbed without leaving idle. Configuration writes are always accepted.
module cubic_curve_tessellator import cct_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	cct_vtx_if.sink   vtx,
	cct_pt_if.source  pt,
	cct_cfg_if.sink   cfg
);

	state_t state_q, state_d;
	logic [4:0] k_q;

	logic          mode_q;
	logic [SW-1:0] steps_q;
	logic [SW-1:0] s_q;
	logic [2:0]    fill_q, fill_n;
	logic [1:0]    phase_q, phase_n;
	logic          emit;

	vertex_t win_q [4];

	logic [16:0]   a_q;
	logic [SW-1:0] b_q;
	logic [16:0]   t_q;
	logic [SW-1:0] r_q;
	logic [SW-1:0] j_q;
	logic [16:0]   u;

	logic [32:0] t2_q, u2_q;
	logic [48:0] t3_q, u3_q, tu2_q, t2u_q;
	logic [19:0] wgt_q [4];

	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [PW-1:0] prod_q;
	logic signed [AW-1:0] acc_q;
	coord_t px_q, py_q, pz_q;

	logic last;
	assign last = (j_q == s_q);
	assign u    = 17'h10000 - t_q;

	// Window bookkeeping for the vertex on the input
	always_comb begin
		logic [2:0] fb;
		logic [1:0] pb;
		logic [1:0] p1;
		fb = vtx.new_curve ? 3'd0 : fill_q;
		pb = vtx.new_curve ? 2'd0 : phase_q;
		p1 = pb + 2'd1;
		emit    = 1'b0;
		fill_n  = fb;
		phase_n = pb;
		if (fb < 3'd4) begin
			fill_n = fb + 3'd1;
			emit   = (fill_n == 3'd4);
			if (emit) phase_n = 2'd0;
		end else if (mode_q == MODE_BEZIER) begin
			emit    = (p1 >= 2'd3);
			phase_n = emit ? 2'd0 : p1;
		end else begin
			emit = 1'b1;
		end
		if (mode_q != MODE_BEZIER) phase_n = 2'd0;
	end

	// Sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (vtx.valid && emit) state_d = ST_DIV;
			ST_DIV:  if (k_q == 5'd16) state_d = ST_PWR;
			ST_PWR:  if (k_q == 5'd6) state_d = ST_WNUM;
			ST_WNUM: if (k_q == 5'd3) state_d = (mode_q == MODE_BSPLINE) ? ST_WDIV : ST_DOT;
			ST_WDIV: if (k_q == 5'd4) state_d = ST_DOT;
			ST_DOT:  if (k_q == 5'd12) state_d = ST_OUT;
			ST_OUT:  if (pt.ready) state_d = last ? ST_IDLE : ST_PWR;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			k_q     <= (state_d != state_q) ? 5'd0 : k_q + 5'd1;
		end
	end

	// Configuration and window control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BEZIER;
			steps_q <= SW'(10);
			fill_q  <= '0;
			phase_q <= '0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == REG_MODE) mode_q <= cfg.data[0];
				else if (cfg.index == REG_STEPS) steps_q <= cfg.data;
			end
			if (state_q == ST_IDLE && vtx.valid) begin
				fill_q  <= fill_n;
				phase_q <= phase_n;
			end
		end
	end

	assign cfg.ready = 1'b1;

	// Shared multiplier operand select
	always_comb begin
		logic [1:0] i;
		coord_t     c;
		i     = k_q[1:0];
		c     = win_q[i].x;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_PWR: begin
				unique case (k_q)
					5'd0: begin mul_a = MA'(t_q); mul_b = MB'(t_q); end
					5'd1: begin mul_a = MA'(u); mul_b = MB'(u); end
					5'd2: begin mul_a = MA'(t2_q); mul_b = MB'(t_q); end
					5'd3: begin mul_a = MA'(u2_q); mul_b = MB'(u); end
					5'd4: begin mul_a = MA'(u2_q); mul_b = MB'(t_q); end
					5'd5: begin mul_a = MA'(t2_q); mul_b = MB'(u); end
					default: ;
				endcase
			end
			ST_WDIV: begin
				mul_a = MA'(wgt_q[i]);
				mul_b = MB'(RECIP6);
			end
			ST_DOT: begin
				unique case (k_q[3:2])
					2'd0:    c = win_q[i].x;
					2'd1:    c = win_q[i].y;
					default: c = win_q[i].z;
				endcase
				mul_a = MA'(wgt_q[i]);
				mul_b = MB'(c);
			end
			default: ;
		endcase
	end

	// Datapath
	always_ff @(posedge clk) begin
		logic [SW:0]          remx;
		logic [SW:0]          rsum;
		logic signed [53:0]   n;
		logic [53:0]          nr;
		logic [3:0]           kk;
		logic signed [AW-1:0] s;
		logic signed [AW-1:0] rs;
		logic signed [AW-17:0] rr;
		coord_t               sat;

		prod_q <= mul_a * mul_b;

		unique case (state_q)
			ST_IDLE: begin
				if (vtx.valid) begin
					win_q[0] <= win_q[1];
					win_q[1] <= win_q[2];
					win_q[2] <= win_q[3];
					win_q[3] <= '{x: vtx.vx, y: vtx.vy, z: vtx.vz};
					s_q <= (steps_q == '0) ? SW'(1) :
						((steps_q > SW'(MAX_STEPS)) ? SW'(MAX_STEPS) : steps_q);
					a_q <= '0;
					b_q <= '0;
				end
			end
			ST_DIV: begin
				// Restoring divide of 65536 by the step count
				remx = {b_q, (k_q == 5'd0)};
				if (remx >= {1'b0, s_q}) begin
					b_q <= SW'(remx - {1'b0, s_q});
					a_q <= {a_q[15:0], 1'b1};
				end else begin
					b_q <= remx[SW-1:0];
					a_q <= {a_q[15:0], 1'b0};
				end
				t_q <= '0;
				r_q <= s_q >> 1;
				j_q <= '0;
			end
			ST_PWR: begin
				unique case (k_q)
					5'd1: t2_q  <= prod_q[32:0];
					5'd2: u2_q  <= prod_q[32:0];
					5'd3: t3_q  <= prod_q[48:0];
					5'd4: u3_q  <= prod_q[48:0];
					5'd5: tu2_q <= prod_q[48:0];
					5'd6: t2u_q <= prod_q[48:0];
					default: ;
				endcase
			end
			ST_WNUM: begin
				// Weight numerators on a 2^48 scale
				if (mode_q == MODE_BEZIER) begin
					unique case (k_q[1:0])
						2'd0: n = 54'(u3_q);
						2'd1: n = 54'(tu2_q) * 54'sd3;
						2'd2: n = 54'(t2u_q) * 54'sd3;
						default: n = 54'(t3_q);
					endcase
					nr = 54'(n) + (54'd1 << 31);
				end else begin
					unique case (k_q[1:0])
						2'd0: n = 54'(u3_q);
						2'd1: n = 54'(t3_q) * 54'sd3 - (54'(t2_q) << 17) - (54'(t2_q) << 18)
							+ (54'sd1 <<< 50);
						2'd2: n = (54'(t2_q) << 16) * 54'sd3 + (54'(t_q) << 32) * 54'sd3
							+ (54'sd1 <<< 48) - 54'(t3_q) * 54'sd3;
						default: n = 54'(t3_q);
					endcase
					nr = 54'(n) + (54'd3 << 32);
				end
				wgt_q[k_q[1:0]] <= nr[51:32];
			end
			ST_WDIV: begin
				// Divide by six through the reciprocal
				if (k_q != 5'd0)
					wgt_q[2'(k_q - 5'd1)] <= 20'(prod_q >>> RECIP6_SHIFT);
			end
			ST_DOT: begin
				if (k_q != 5'd0) begin
					kk = 4'(k_q - 5'd1);
					s  = (kk[1:0] == 2'd0) ? AW'(prod_q) : acc_q + AW'(prod_q);
					acc_q <= s;
					if (kk[1:0] == 2'd3) begin
						// Round half up to Q8.8 and saturate
						rs = s + (AW'(1) <<< 15);
						rr = rs[AW-1:16];
						if (rr > (AW-16)'($signed({1'b0, {(CW-1){1'b1}}})))
							sat = {1'b0, {(CW-1){1'b1}}};
						else if (rr < -(AW-16)'($signed({1'b0, {(CW-1){1'b1}}})) - 1)
							sat = {1'b1, {(CW-1){1'b0}}};
						else
							sat = rr[CW-1:0];
						unique case (kk[3:2])
							2'd0:    px_q <= sat;
							2'd1:    py_q <= sat;
							default: pz_q <= sat;
						endcase
					end
				end
			end
			ST_OUT: begin
				// Advance t by 65536/steps with rounding remainder
				if (pt.ready) begin
					rsum = {1'b0, r_q} + {1'b0, b_q};
					j_q  <= j_q + SW'(1);
					if (rsum >= {1'b0, s_q}) begin
						r_q <= SW'(rsum - {1'b0, s_q});
						t_q <= t_q + a_q + 17'd1;
					end else begin
						r_q <= rsum[SW-1:0];
						t_q <= t_q + a_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign vtx.ready     = (state_q == ST_IDLE);
	assign pt.valid      = (state_q == ST_OUT);
	assign pt.px         = px_q;
	assign pt.py         = py_q;
	assign pt.pz         = pz_q;
	assign pt.last_point = last;

endmodule

>>> hw/rtl/cct_checker.sv
module cct_checker import cct_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   out_valid,
	input logic   out_ready,
	input logic   out_last,
	input coord_t out_px,
	input logic   cfg_ready
);

	// Vertices are taken only when no point is pending
	a_idle_excl: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("input ready while point pending");

	// An accepted vertex is never followed directly by a point
	a_in_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("point right after vertex");

	// A stalled point holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_px))
		else $error("stalled point changed");

	// The final point of a segment returns the block to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> in_ready && !out_valid)
		else $error("not idle after last point");

	// Configuration writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready) else $error("configuration port stalled");

endmodule

bind cubic_curve_tessellator cct_checker u_cct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (vtx.valid),
	.in_ready  (vtx.ready),
	.out_valid (pt.valid),
	.out_ready (pt.ready),
	.out_last  (pt.last_point),
	.out_px    (pt.px),
	.cfg_ready (cfg.ready)
);
